>>> hdl/ptc_pkg.sv
// Shared types and constants for the pressure/temperature compensation block.
package ptc_pkg;

   localparam int unsigned AdcWidth   = 20;
   localparam int unsigned ValueWidth = 32;
   localparam int unsigned WordWidth  = 64;
   localparam int unsigned CsrIdxWidth = 3;

   localparam logic [CsrIdxWidth-1:0] CSR_CAL_TEMP    = 3'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_CAL_PRESS_A = 3'd1;
   localparam logic [CsrIdxWidth-1:0] CSR_CAL_PRESS_B = 3'd2;
   localparam logic [CsrIdxWidth-1:0] CSR_CAL_PRESS_C = 3'd3;

   localparam logic [WordWidth-1:0] T_FINE_OFFSET = 64'd128000;
   localparam logic [WordWidth-1:0] P1_BIAS       = 64'h0000_8000_0000_0000;
   localparam logic [WordWidth-1:0] P_SCALE       = 64'd3125;
   localparam logic [AdcWidth:0]    ADC_FULL      = 21'd1048576;
   localparam logic [31:0]          T_ROUND       = 32'd128;

   // Micro-operations, in program order
   typedef enum logic [4:0] {
      T_A, T_M1, T_B, T_M2, T_M3, T_F,
      P_A, P_M1, P_M2, P_M3, P_M4, P_M5, P_M6, P_CHK,
      P_M7, P_DIV, P_M8, P_M9, P_M10, P_F
   } uop_type;

   typedef enum logic [1:0] {K_ALU, K_MUL, K_DIV} kind_type;

   typedef enum logic [2:0] {S_IDLE, S_ISSUE, S_WAIT_MUL, S_WAIT_DIV, S_FINISH} state_type;

   typedef struct packed {
      uop_type uop;
      logic    load;
      logic    go;
      logic    wb;
   } cmd_type;

   typedef struct packed {
      logic mul_done;
      logic div_done;
      logic div_zero;
   } status_type;

   function automatic kind_type uop_kind(uop_type u);
      kind_type k;
      unique case (u)
         T_A, T_B, T_F, P_A, P_CHK, P_F: k = K_ALU;
         P_DIV:                          k = K_DIV;
         default:                        k = K_MUL;
      endcase
      return k;
   endfunction

   function automatic logic [WordWidth-1:0] sx16(logic [15:0] w);
      return {{48{w[15]}}, w};
   endfunction

endpackage

>>> hdl/ptc_div.sv
// Signed 64-bit restoring divider, one quotient bit per cycle.
module ptc_div
   import ptc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [WordWidth-1:0] num,
   input  logic [WordWidth-1:0] den,
   output logic [WordWidth-1:0] quot,
   output logic                 done
);

   logic [WordWidth-1:0] q_ff, q_in;
   logic [WordWidth-1:0] rem_ff, rem_in;
   logic [WordWidth-1:0] den_ff, den_in;
   logic                 neg_ff, neg_in;
   logic [5:0]           cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [WordWidth:0]   trial;

   always_comb begin
      q_in    = q_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, q_ff[WordWidth-1]};
      if (start) begin
         q_in    = num[WordWidth-1] ? (~num + 64'd1) : num;
         den_in  = den[WordWidth-1] ? (~den + 64'd1) : den;
         neg_in  = num[WordWidth-1] ^ den[WordWidth-1];
         rem_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = 64'(trial - {1'b0, den_ff});
            q_in   = {q_ff[WordWidth-2:0], 1'b1};
         end else begin
            rem_in = trial[WordWidth-1:0];
            q_in   = {q_ff[WordWidth-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd63) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      q_ff   <= q_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
   end

   assign quot = neg_ff ? (~q_ff + 64'd1) : q_ff;
   assign done = done_ff;

endmodule

>>> hdl/ptc_datapath.sv
// Datapath: calibration registers, scratch registers, shared multiplier and divider.
module ptc_datapath
   import ptc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  cmd_type                cmd,
   output status_type             status,
   input  logic                   in_command,
   input  logic [AdcWidth-1:0]    in_adc,
   input  logic                   csr_we,
   input  logic [CsrIdxWidth-1:0] csr_idx,
   input  logic [WordWidth-1:0]   csr_wdata,
   output logic [ValueWidth-1:0]  out_value,
   output logic                   out_pressure,
   output logic                   out_div_zero
);

   logic [47:0]          cal_temp_ff;
   logic [63:0]          cal_pa_ff, cal_pb_ff;
   logic [15:0]          cal_pc_ff;
   logic [31:0]          t_fine_ff, t_fine_in;
   logic [AdcWidth-1:0]  adc_ff;
   logic                 press_ff;
   logic [63:0]          ra_ff, ra_in, rb_ff, rb_in, rc_ff, rc_in, rd_ff, rd_in;
   logic [31:0]          res_ff, res_in;
   logic                 dz_ff, dz_in;

   // shared multiplier: low 64 bits of a*b, one 16-bit slice of b per cycle
   logic [63:0] mul_a, mul_b;
   logic [63:0] ma_ff, mb_ff, acc_ff;
   logic [1:0]  mcnt_ff;
   logic        mbusy_ff, mdone_ff;
   logic [79:0] partial;
   logic        mul_start;

   logic [63:0] quot;
   logic        div_done;
   logic        div_start;

   logic [63:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
   logic [31:0] tf, tf5;
   logic [63:0] ph, psum;
   logic [AdcWidth:0] pdiff;

   assign t1 = {48'b0, cal_temp_ff[15:0]};
   assign t2 = sx16(cal_temp_ff[31:16]);
   assign t3 = sx16(cal_temp_ff[47:32]);
   assign p1 = {48'b0, cal_pa_ff[15:0]};
   assign p2 = sx16(cal_pa_ff[31:16]);
   assign p3 = sx16(cal_pa_ff[47:32]);
   assign p4 = sx16(cal_pa_ff[63:48]);
   assign p5 = sx16(cal_pb_ff[15:0]);
   assign p6 = sx16(cal_pb_ff[31:16]);
   assign p7 = sx16(cal_pb_ff[47:32]);
   assign p8 = sx16(cal_pb_ff[63:48]);
   assign p9 = sx16(cal_pc_ff);

   assign tf    = rc_ff[31:0] + ra_ff[31:0];
   assign tf5   = (tf << 2) + tf + T_ROUND;
   assign ph    = $signed(rb_ff) >>> 13;
   assign psum  = rb_ff + rd_ff + rc_ff;
   assign pdiff = ADC_FULL - {1'b0, adc_ff};

   assign mul_start = cmd.go && (uop_kind(cmd.uop) == K_MUL);
   assign div_start = cmd.go && (uop_kind(cmd.uop) == K_DIV);

   always_comb begin
      unique case (cmd.uop)
         T_M1:    begin mul_a = ra_ff;           mul_b = t2;      end
         T_M2:    begin mul_a = ra_ff;           mul_b = ra_ff;   end
         T_M3:    begin mul_a = ra_ff;           mul_b = t3;      end
         P_M1:    begin mul_a = ra_ff;           mul_b = ra_ff;   end
         P_M2:    begin mul_a = rb_ff;           mul_b = p6;      end
         P_M3:    begin mul_a = ra_ff;           mul_b = p5;      end
         P_M4:    begin mul_a = rb_ff;           mul_b = p3;      end
         P_M5:    begin mul_a = ra_ff;           mul_b = p2;      end
         P_M6:    begin mul_a = P1_BIAS + rd_ff; mul_b = p1;      end
         P_M7:    begin mul_a = ({43'b0, pdiff} << 31) - rc_ff; mul_b = P_SCALE; end
         P_M8:    begin mul_a = ph;              mul_b = p9;      end
         P_M9:    begin mul_a = rd_ff;           mul_b = ph;      end
         P_M10:   begin mul_a = rb_ff;           mul_b = p8;      end
         default: begin mul_a = ra_ff;           mul_b = rb_ff;   end
      endcase
   end

   assign partial = ma_ff * mb_ff[15:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         mbusy_ff <= 1'b0;
         mdone_ff <= 1'b0;
      end else begin
         mdone_ff <= mbusy_ff && (mcnt_ff == 2'd3);
         if (mul_start) begin
            mbusy_ff <= 1'b1;
         end else if (mcnt_ff == 2'd3) begin
            mbusy_ff <= 1'b0;
         end
      end
      if (mul_start) begin
         ma_ff   <= mul_a;
         mb_ff   <= mul_b;
         acc_ff  <= '0;
         mcnt_ff <= '0;
      end else if (mbusy_ff) begin
         acc_ff  <= acc_ff + partial[63:0];
         ma_ff   <= ma_ff << 16;
         mb_ff   <= mb_ff >> 16;
         mcnt_ff <= mcnt_ff + 2'd1;
      end
   end

   ptc_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (rb_ff),
      .den   (ra_ff),
      .quot  (quot),
      .done  (div_done)
   );

   always_comb begin
      ra_in     = ra_ff;
      rb_in     = rb_ff;
      rc_in     = rc_ff;
      rd_in     = rd_ff;
      res_in    = res_ff;
      dz_in     = dz_ff;
      t_fine_in = t_fine_ff;
      if (cmd.go && (uop_kind(cmd.uop) == K_ALU)) begin
         unique case (cmd.uop)
            T_A:   ra_in = {44'b0, adc_ff >> 3} - (t1 << 1);
            T_B:   ra_in = {44'b0, adc_ff >> 4} - t1;
            T_F: begin
               t_fine_in = tf;
               res_in    = $signed(tf5) >>> 8;
               dz_in     = 1'b0;
            end
            P_A:   ra_in = {{32{t_fine_ff[31]}}, t_fine_ff} - T_FINE_OFFSET;
            P_CHK: begin
               res_in = '0;
               dz_in  = (ra_ff == '0);
            end
            P_F: begin
               res_in = 32'(64'($signed(psum) >>> 8) + (p7 << 4));
               dz_in  = 1'b0;
            end
            default: ;
         endcase
      end
      if (cmd.wb) begin
         unique case (cmd.uop)
            T_M1:  rc_in = {32'b0, 32'($signed(acc_ff[31:0]) >>> 11)};
            T_M2:  ra_in = {32'b0, 32'($signed(acc_ff[31:0]) >>> 12)};
            T_M3:  ra_in = {32'b0, 32'($signed(acc_ff[31:0]) >>> 14)};
            P_M1:  rb_in = acc_ff;
            P_M2:  rc_in = acc_ff;
            P_M3:  rc_in = rc_ff + (acc_ff << 17) + (p4 << 35);
            P_M4:  rd_in = $signed(acc_ff) >>> 8;
            P_M5:  rd_in = rd_ff + (acc_ff << 12);
            P_M6:  ra_in = $signed(acc_ff) >>> 33;
            P_M7:  rb_in = acc_ff;
            P_DIV: rb_in = quot;
            P_M8:  rd_in = acc_ff;
            P_M9:  rd_in = $signed(acc_ff) >>> 25;
            P_M10: rc_in = $signed(acc_ff) >>> 19;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_temp_ff <= '0;
         cal_pa_ff   <= '0;
         cal_pb_ff   <= '0;
         cal_pc_ff   <= '0;
         t_fine_ff   <= '0;
      end else begin
         t_fine_ff <= t_fine_in;
         if (csr_we) begin
            unique case (csr_idx)
               CSR_CAL_TEMP:    cal_temp_ff <= csr_wdata[47:0];
               CSR_CAL_PRESS_A: cal_pa_ff   <= csr_wdata;
               CSR_CAL_PRESS_B: cal_pb_ff   <= csr_wdata;
               CSR_CAL_PRESS_C: cal_pc_ff   <= csr_wdata[15:0];
               default: ;
            endcase
         end
      end
      if (cmd.load) begin
         adc_ff   <= in_adc;
         press_ff <= in_command;
      end
      ra_ff  <= ra_in;
      rb_ff  <= rb_in;
      rc_ff  <= rc_in;
      rd_ff  <= rd_in;
      res_ff <= res_in;
      dz_ff  <= dz_in;
   end

   assign status.mul_done = mdone_ff;
   assign status.div_done = div_done;
   assign status.div_zero = (ra_ff == '0);

   assign out_value    = res_ff;
   assign out_pressure = press_ff;
   assign out_div_zero = dz_ff;

endmodule

>>> hdl/ptc_ctrl.sv
// Controller: sequences the micro-operations for one sample.
module ptc_ctrl
   import ptc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   input  logic       in_command,
   output logic       in_ready,
   output logic       out_valid,
   input  logic       out_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;
   uop_type   step_ff, step_in;
   uop_type   step_next;

   assign step_next = uop_type'(step_ff + 5'd1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         step_ff  <= T_A;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      cmd.uop   = step_ff;
      cmd.load  = 1'b0;
      cmd.go    = 1'b0;
      cmd.wb    = 1'b0;
      in_ready  = 1'b0;
      out_valid = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            in_ready = 1'b1;
            if (in_valid) begin
               cmd.load = 1'b1;
               step_in  = in_command ? P_A : T_A;
               state_in = S_ISSUE;
            end
         end
         S_ISSUE: begin
            cmd.go = 1'b1;
            unique case (uop_kind(step_ff))
               K_MUL: state_in = S_WAIT_MUL;
               K_DIV: state_in = S_WAIT_DIV;
               default: begin
                  if (step_ff == T_F || step_ff == P_F ||
                      (step_ff == P_CHK && status.div_zero)) begin
                     state_in = S_FINISH;
                  end else begin
                     step_in = step_next;
                  end
               end
            endcase
         end
         S_WAIT_MUL: begin
            if (status.mul_done) begin
               cmd.wb   = 1'b1;
               step_in  = step_next;
               state_in = S_ISSUE;
            end
         end
         S_WAIT_DIV: begin
            if (status.div_done) begin
               cmd.wb   = 1'b1;
               step_in  = step_next;
               state_in = S_ISSUE;
            end
         end
         S_FINISH: begin
            out_valid = 1'b1;
            if (out_ready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule

>>> hdl/pressure_temperature_compensation.sv
// Top level: barometric sensor compensation, controller plus datapath.
// One sample at a time; a pressure sample finishes early when the divisor is zero.
// Ten multiplies on the shared 64x16 multiplier and a bit-serial divide set the
// pressure latency.
// A new sample is taken the cycle after the result is taken.
// Synchronous reset clears calibration registers, the fine temperature and control.
module pressure_temperature_compensation
   import ptc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [23:0]            req_tdata,   // [19:0] adc_value
   input  logic                   req_tuser,   // [0] command
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [31:0]            rsp_tdata,   // [31:0] value
   output logic [1:0]             rsp_tuser,   // [0] was_pressure, [1] div_zero
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CsrIdxWidth-1:0] csr_index,
   input  logic [WordWidth-1:0]   csr_data
);

   cmd_type    cmd;
   status_type status;
   logic       pressure;
   logic       div_zero;

   assign csr_ready = 1'b1;

   ptc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_command (req_tuser),
      .in_ready   (req_tready),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   ptc_datapath u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .in_command   (req_tuser),
      .in_adc       (req_tdata[AdcWidth-1:0]),
      .csr_we       (csr_valid && csr_ready),
      .csr_idx      (csr_index),
      .csr_wdata    (csr_data),
      .out_value    (rsp_tdata),
      .out_pressure (pressure),
      .out_div_zero (div_zero)
   );

   assign rsp_tuser = {div_zero, pressure};

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("input ready while a result is pending");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("second transaction taken during processing");

   a_dz_pressure: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[1]) |-> rsp_tuser[0])
      else $error("div_zero on a temperature result");

   a_dz_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[1]) |-> (rsp_tdata == '0))
      else $error("nonzero value with div_zero");

endmodule
